/* hw/rtl/bcbc_pkg.sv */
package bcbc_pkg;

	// Field widths of the observation and result transactions.
	localparam int RANGE_W = 36;
	localparam int ELEV_W  = 16;
	localparam int PRN_W   = 6;

	// One lane per carrier frequency (B1, B2, B3).
	localparam int NUM_LANES = 3;

	// Correction tables: one entry every 10 degrees, 0 to 90 degrees.
	localparam int TAB_LEN  = 10;
	localparam int LAST_SEG = TAB_LEN - 1;
	localparam int TAB_W    = 12;
	localparam int SEG_W    = 4;
	localparam int REM_W    = 12;

	// Satellite classes by PRN.
	localparam int FIRST_IGSO = 6;
	localparam int FIRST_MEO  = 11;

	// Elevation scaling: 2560 units of 1/256 degree per table step.
	localparam int STEP_DEG    = 10;
	localparam int DEG_W       = 7;
	localparam int TOP_ELEV    = 23040;
	localparam int SEG_RECIP   = 205;
	localparam int SEG_SHIFT   = 11;
	localparam int SEG_PROD_W  = 15;

	// Interpolation arithmetic. The offset keeps the numerator positive so
	// that floor division by 2560 becomes a shift by 9 and a divide by 5.
	localparam int BIAS_Q     = 400;
	localparam int STEP_UNITS = 2560;
	localparam int ROUND_BIAS = STEP_UNITS / 2 + BIAS_Q * STEP_UNITS;
	localparam int DIFF_W     = 13;
	localparam int PROD_W     = 26;
	localparam int T_W        = 21;
	localparam int U_W        = 12;
	localparam int RECIP_5    = 52429;
	localparam int RECIP_SHIFT = 18;
	localparam int QP_W       = 28;
	localparam int Q_W        = 10;
	localparam int CORR_W     = 13;
	localparam int SUM_W      = RANGE_W + 2;

	localparam int IGSO_MM [NUM_LANES][TAB_LEN] = '{
		'{-550, -400, -340, -230, -150, -40, 90, 190, 270, 350},
		'{-710, -360, -330, -190, -140, -30, 80, 170, 240, 330},
		'{-270, -230, -210, -150, -110, -40, 50, 140, 190, 320}
	};

	localparam int MEO_MM [NUM_LANES][TAB_LEN] = '{
		'{-470, -380, -320, -230, -110, 60, 340, 690, 970, 1050},
		'{-400, -310, -260, -180, -60, 90, 280, 480, 640, 690},
		'{-220, -150, -130, -100, -40, 50, 140, 270, 360, 470}
	};

	typedef struct packed {
		logic                     is_beidou;
		logic [PRN_W-1:0]         prn;
		logic signed [ELEV_W-1:0] elevation;
		logic [RANGE_W-1:0]       range_b1;
		logic [RANGE_W-1:0]       range_b2;
		logic [RANGE_W-1:0]       range_b3;
		logic                     last_in_epoch;
	} obs_t;

	typedef struct packed {
		logic [RANGE_W-1:0] corrected_b1;
		logic [RANGE_W-1:0] corrected_b2;
		logic [RANGE_W-1:0] corrected_b3;
		logic               applied;
		logic               epoch_end;
	} res_t;

	// Per-observation control shared by all lanes.
	typedef struct packed {
		logic             apply;
		logic             is_meo;
		logic [SEG_W-1:0] seg;
		logic [REM_W-1:0] rem;
	} ctl_t;

	// Table lookup; indexes past the last entry read as zero.
	function automatic logic signed [TAB_W-1:0] corr_entry(
		input logic is_meo,
		input int lane,
		input logic [SEG_W-1:0] idx
	);
		logic signed [TAB_W-1:0] val;
		val = '0;
		if (idx <= SEG_W'(LAST_SEG)) begin
			if (is_meo) begin
				val = TAB_W'(MEO_MM[lane][idx]);
			end else begin
				val = TAB_W'(IGSO_MM[lane][idx]);
			end
		end
		return val;
	endfunction

endpackage

/* hw/rtl/bcbc_lane.sv */
module bcbc_lane #(
	parameter int LANE = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  bcbc_pkg::ctl_t                 ctl_s1,
	input  logic [bcbc_pkg::RANGE_W-1:0]   range_s1,
	output logic [bcbc_pkg::RANGE_W-1:0]   corrected_s4
);

	// Stage 2 signals.
	logic signed [bcbc_pkg::TAB_W-1:0]  lo;
	logic signed [bcbc_pkg::TAB_W-1:0]  hi;
	logic signed [bcbc_pkg::DIFF_W-1:0] diff;
	logic signed [bcbc_pkg::PROD_W-1:0] prod;
	logic signed [bcbc_pkg::PROD_W-1:0] numer;
	logic [bcbc_pkg::T_W-1:0]           t_s2;
	logic signed [bcbc_pkg::TAB_W-1:0]  base_s2;
	logic                               apply_s2;
	logic [bcbc_pkg::RANGE_W-1:0]       range_s2;

	// Stage 3 signals.
	logic [bcbc_pkg::U_W-1:0]            u;
	logic [bcbc_pkg::QP_W-1:0]           qprod;
	logic [bcbc_pkg::Q_W-1:0]            q;
	logic signed [bcbc_pkg::CORR_W-1:0]  corr;
	logic signed [bcbc_pkg::CORR_W-1:0]  corr_s3;
	logic [bcbc_pkg::RANGE_W-1:0]        range_s3;

	// Stage 4 signals.
	logic signed [bcbc_pkg::SUM_W-1:0] sum;
	logic [bcbc_pkg::RANGE_W-1:0]      sat;

	// Look up the neighboring entries and form the biased interpolation numerator.
	always_comb begin
		lo    = bcbc_pkg::corr_entry(ctl_s1.is_meo, LANE, ctl_s1.seg);
		hi    = bcbc_pkg::corr_entry(ctl_s1.is_meo, LANE, ctl_s1.seg + 1'b1);
		diff  = bcbc_pkg::DIFF_W'(hi) - bcbc_pkg::DIFF_W'(lo);
		prod  = bcbc_pkg::PROD_W'(diff) * bcbc_pkg::PROD_W'($signed({1'b0, ctl_s1.rem}));
		numer = prod + bcbc_pkg::PROD_W'(bcbc_pkg::ROUND_BIAS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2     <= numer[bcbc_pkg::T_W-1:0];
			base_s2  <= lo;
			apply_s2 <= ctl_s1.apply;
			range_s2 <= range_s1;
		end
	end

	// Floor division by 2560: drop nine bits, then multiply by the reciprocal of 5.
	always_comb begin
		u     = t_s2[bcbc_pkg::T_W-1:bcbc_pkg::T_W-bcbc_pkg::U_W];
		qprod = bcbc_pkg::QP_W'(u) * bcbc_pkg::QP_W'(bcbc_pkg::RECIP_5);
		q     = qprod[bcbc_pkg::QP_W-1:bcbc_pkg::RECIP_SHIFT];
		corr  = bcbc_pkg::CORR_W'(base_s2) + $signed({3'b000, q})
			- bcbc_pkg::CORR_W'(bcbc_pkg::BIAS_Q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corr_s3  <= apply_s2 ? corr : '0;
			range_s3 <= range_s2;
		end
	end

	// Add the correction and saturate to the unsigned range.
	always_comb begin
		sum = $signed({2'b00, range_s3}) + bcbc_pkg::SUM_W'(corr_s3);
		if (sum[bcbc_pkg::SUM_W-1]) begin
			sat = '0;
		end else if (sum[bcbc_pkg::RANGE_W]) begin
			sat = '1;
		end else begin
			sat = sum[bcbc_pkg::RANGE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corrected_s4 <= sat;
		end
	end

endmodule

/* hw/rtl/bcbc_merge.sv */
module bcbc_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic [bcbc_pkg::RANGE_W-1:0] lane_range [bcbc_pkg::NUM_LANES],
	input  logic                         up_applied,
	input  logic                         up_epoch_end,
	output logic                         res_valid,
	input  logic                         res_ready,
	output bcbc_pkg::res_t               res
);

	bcbc_pkg::res_t merged;
	bcbc_pkg::res_t out_q;
	bcbc_pkg::res_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;

	// Combine the lane results and the sideband into one result transaction.
	always_comb begin
		merged.corrected_b1 = lane_range[0];
		merged.corrected_b2 = lane_range[1];
		merged.corrected_b3 = lane_range[2];
		merged.applied      = up_applied;
		merged.epoch_end    = up_epoch_end;
	end

	assign up_ready  = !skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Output register with a skid entry so the upstream ready is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= up_valid;
			end
		end else if (up_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (up_valid && !skid_valid_q) begin
			skid_q <= merged;
		end
	end

endmodule

/* hw/rtl/beidou_code_bias_correction_unit.sv */
// BeiDou satellite-induced code bias correction.
//
// Observations enter on the obs channel (obs_valid/obs_ready, payload obs) and
// corrected pseudoranges leave on the res channel (res_valid/res_ready, payload
// res), one result transaction per observation, in order. IGSO and MEO satellites
// get an elevation-interpolated correction per frequency; everything else passes
// through with applied low.
//
// The datapath is a four-stage pipeline with three lanes, one per frequency,
// followed by an output register that every result passes through. Throughput
// is one transaction per cycle while the receiver does not stall, set by the
// single multiplier in each of the two arithmetic stages of every lane.
//
// When the receiver stalls, the output holds and one more transaction lands in a
// skid entry; obs_ready then drops the next cycle and the whole pipeline freezes
// until the output is taken. obs_ready comes from a register, not from res_ready.
// Reset clears all valid flags; obs_ready is high out of reset.
module beidou_code_bias_correction_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           obs_valid,
	output logic           obs_ready,
	input  bcbc_pkg::obs_t obs,
	output logic           res_valid,
	input  logic           res_ready,
	output bcbc_pkg::res_t res
);

	logic                               en;
	logic [bcbc_pkg::DEG_W-1:0]         deg;
	logic [bcbc_pkg::SEG_PROD_W-1:0]    seg_prod;
	logic [bcbc_pkg::SEG_W-1:0]         seg_raw;
	logic [bcbc_pkg::DEG_W-1:0]         deg_rem;
	logic                               clamp;
	bcbc_pkg::ctl_t                     ctl;

	bcbc_pkg::ctl_t                     ctl_s1;
	logic [bcbc_pkg::RANGE_W-1:0]       range_s1 [bcbc_pkg::NUM_LANES];
	logic [bcbc_pkg::RANGE_W-1:0]       corrected_s4 [bcbc_pkg::NUM_LANES];
	logic                               valid_s1, valid_s2, valid_s3, valid_s4;
	logic                               epoch_s1, epoch_s2, epoch_s3, epoch_s4;
	logic                               applied_s2, applied_s3, applied_s4;

	assign obs_ready = en;

	// Classify the satellite and split the elevation into table step and remainder.
	always_comb begin
		deg      = obs.elevation[14:8];
		seg_prod = bcbc_pkg::SEG_PROD_W'(deg) * bcbc_pkg::SEG_PROD_W'(bcbc_pkg::SEG_RECIP);
		seg_raw  = seg_prod[bcbc_pkg::SEG_PROD_W-1:bcbc_pkg::SEG_SHIFT];
		deg_rem  = deg - bcbc_pkg::DEG_W'(seg_raw) * bcbc_pkg::DEG_W'(bcbc_pkg::STEP_DEG);
		clamp    = obs.elevation >= $signed(bcbc_pkg::ELEV_W'(bcbc_pkg::TOP_ELEV));

		ctl.apply  = obs.is_beidou && (obs.prn >= bcbc_pkg::PRN_W'(bcbc_pkg::FIRST_IGSO))
			&& (obs.elevation > $signed(bcbc_pkg::ELEV_W'(0)));
		ctl.is_meo = obs.prn >= bcbc_pkg::PRN_W'(bcbc_pkg::FIRST_MEO);
		if (clamp) begin
			ctl.seg = bcbc_pkg::SEG_W'(bcbc_pkg::LAST_SEG);
			ctl.rem = '0;
		end else begin
			ctl.seg = seg_raw;
			ctl.rem = {deg_rem[bcbc_pkg::SEG_W-1:0], obs.elevation[7:0]};
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1      <= ctl;
			range_s1[0] <= obs.range_b1;
			range_s1[1] <= obs.range_b2;
			range_s1[2] <= obs.range_b3;
			epoch_s1    <= obs.last_in_epoch;
			epoch_s2    <= epoch_s1;
			epoch_s3    <= epoch_s2;
			epoch_s4    <= epoch_s3;
			applied_s2  <= ctl_s1.apply;
			applied_s3  <= applied_s2;
			applied_s4  <= applied_s3;
		end
	end

	// Valid flags advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= obs_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// One correction lane per frequency.
	for (genvar i = 0; i < bcbc_pkg::NUM_LANES; i++) begin : g_lane
		bcbc_lane #(
			.LANE(i)
		) u_lane (
			.clk          (clk),
			.en           (en),
			.ctl_s1       (ctl_s1),
			.range_s1     (range_s1[i]),
			.corrected_s4 (corrected_s4[i])
		);
	end

	// Merge lanes into the result and hold it for the receiver.
	bcbc_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (valid_s4),
		.up_ready     (en),
		.lane_range   (corrected_s4),
		.up_applied   (applied_s4),
		.up_epoch_end (epoch_s4),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

endmodule

/* hw/rtl/bcbc_checker.sv */
module bcbc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           obs_ready,
	input logic           res_valid,
	input logic           res_ready,
	input bcbc_pkg::res_t res
);

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The input side only closes after the output was stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(obs_ready) |-> $past(res_valid && !res_ready))
		else $error("obs_ready dropped without an output stall");

	// With nothing waiting at the output, the skid entry is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> obs_ready)
		else $error("obs_ready low with an empty output");

	// A closed input side reopens only once the held result is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(obs_ready) |-> $past(res_valid && res_ready))
		else $error("obs_ready rose without an output transaction");

endmodule

bind beidou_code_bias_correction_unit bcbc_checker u_bcbc_checker (.*);

/* tb/bcbc_range_checker.sv */
// Watches both channels of the code bias correction unit, predicts each
// corrected observation and compares it with what the unit returns.
module bcbc_range_checker
	import bcbc_pkg::*;
(
	input  logic clk,
	input  logic obs_valid,
	input  logic obs_ready,
	input  obs_t obs,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   fail_count,
	output int   pending,
	output int   checked_count,
	output int   igso_count,
	output int   meo_count,
	output int   clamp_count
);

	localparam int MAX_REPORTS = 10;
	localparam int DEG10 = 2560;
	localparam int HALF_DEG10 = 1280;
	localparam int ELEV_CLAMP = 23040;
	localparam int LAST_ENTRY = 9;
	localparam longint RANGE_LIMIT = 64'h0000_000F_FFFF_FFFF;

	// Bias tables in millimetres, rows B1/B2/B3, one entry per 10 degrees.
	localparam int IGSO_BIAS [3][10] = '{
		'{-550, -400, -340, -230, -150, -40, 90, 190, 270, 350},
		'{-710, -360, -330, -190, -140, -30, 80, 170, 240, 330},
		'{-270, -230, -210, -150, -110, -40, 50, 140, 190, 320}
	};
	localparam int MEO_BIAS [3][10] = '{
		'{-470, -380, -320, -230, -110, 60, 340, 690, 970, 1050},
		'{-400, -310, -260, -180, -60, 90, 280, 480, 640, 690},
		'{-220, -150, -130, -100, -40, 50, 140, 270, 360, 470}
	};

	res_t corrected_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
		checked_count = 0;
		igso_count = 0;
		meo_count = 0;
		clamp_count = 0;
	end

	// Interpolated bias for one lane, rounded to the nearest millimetre with
	// halves going up.
	function automatic int lane_bias(input logic is_meo, input int lane, input int e);
		int seg;
		int frac;
		int lo;
		int hi;
		int num;
		int q;
		if (e >= ELEV_CLAMP) begin
			return is_meo ? MEO_BIAS[lane][LAST_ENTRY] : IGSO_BIAS[lane][LAST_ENTRY];
		end
		seg = e / DEG10;
		frac = e - seg * DEG10;
		lo = is_meo ? MEO_BIAS[lane][seg] : IGSO_BIAS[lane][seg];
		hi = is_meo ? MEO_BIAS[lane][seg + 1] : IGSO_BIAS[lane][seg + 1];
		num = lo * DEG10 + (hi - lo) * frac + HALF_DEG10;
		q = num / DEG10;
		// Integer division truncates; step down for negative remainders.
		if (num - q * DEG10 < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// Expected result of one observation; clamps counts lanes that hit a limit.
	function automatic res_t predict_corrected(input obs_t o, output int clamps);
		res_t r;
		int e;
		int bias;
		longint sum;
		logic is_meo;
		logic [RANGE_W-1:0] rng [3];
		logic [RANGE_W-1:0] fixed [3];
		e = $signed(o.elevation);
		rng[0] = o.range_b1;
		rng[1] = o.range_b2;
		rng[2] = o.range_b3;
		clamps = 0;
		r.applied = o.is_beidou && (o.prn >= FIRST_IGSO) && (e > 0);
		is_meo = o.prn >= FIRST_MEO;
		for (int lane = 0; lane < 3; lane++) begin
			fixed[lane] = rng[lane];
			if (r.applied) begin
				bias = lane_bias(is_meo, lane, e);
				sum = longint'(rng[lane]) + bias;
				if (sum < 0) begin
					fixed[lane] = '0;
					clamps++;
				end else if (sum > RANGE_LIMIT) begin
					fixed[lane] = '1;
					clamps++;
				end else begin
					fixed[lane] = sum[RANGE_W-1:0];
				end
			end
		end
		r.corrected_b1 = fixed[0];
		r.corrected_b2 = fixed[1];
		r.corrected_b3 = fixed[2];
		r.epoch_end = o.last_in_epoch;
		return r;
	endfunction

	// Counts a failure and reports the first few of them.
	task automatic flag_field(input string field, input logic [RANGE_W-1:0] want,
			input logic [RANGE_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("Mismatch in result %0d, %s: expected %0d, got %0d",
					checked_count, field, want, got);
			end
		end
	endtask

	// Record expectations for accepted observations and check accepted results.
	always @(posedge clk) begin : watch
		res_t want;
		int clamps;
		if (obs_valid && obs_ready) begin
			want = predict_corrected(obs, clamps);
			corrected_q.push_back(want);
			clamp_count += clamps;
			if (want.applied) begin
				if (obs.prn >= FIRST_MEO) begin
					meo_count++;
				end else begin
					igso_count++;
				end
			end
		end
		if (res_valid && res_ready) begin
			if (corrected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("Result transaction with no observation outstanding: b1 %0d",
						res.corrected_b1);
				end
			end else begin
				want = corrected_q.pop_front();
				flag_field("corrected_b1", want.corrected_b1, res.corrected_b1);
				flag_field("corrected_b2", want.corrected_b2, res.corrected_b2);
				flag_field("corrected_b3", want.corrected_b3, res.corrected_b3);
				flag_field("applied", RANGE_W'(want.applied), RANGE_W'(res.applied));
				flag_field("epoch_end", RANGE_W'(want.epoch_end), RANGE_W'(res.epoch_end));
				checked_count++;
			end
		end
		pending <= corrected_q.size();
	end

endmodule

/* tb/beidou_code_bias_correction_unit_tb.sv */
module beidou_code_bias_correction_unit_tb;
	import bcbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_OBS = 1950;
	localparam int DRAIN_CYCLES = 20;
	localparam int DEG10 = 2560;
	localparam int ELEV_TOP = 23040;
	localparam logic [RANGE_W-1:0] RANGE_TOP = '1;
	localparam logic [RANGE_W-1:0] TYPICAL_RANGE = 36'd21500000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic obs_valid = 1'b0;
	logic obs_ready;
	obs_t obs = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	int fail_count;
	int pending;
	int checked_count;
	int igso_count;
	int meo_count;
	int clamp_count;
	int cycles = 0;
	int stall_left = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	beidou_code_bias_correction_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_ready(obs_ready),
		.obs(obs),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	bcbc_range_checker range_watch (
		.clk(clk),
		.obs_valid(obs_valid),
		.obs_ready(obs_ready),
		.obs(obs),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.fail_count(fail_count),
		.pending(pending),
		.checked_count(checked_count),
		.igso_count(igso_count),
		.meo_count(meo_count),
		.clamp_count(clamp_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the unit hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
			$display("** beidou_code_bias_correction_unit: FAILED **");
			$finish;
		end
	end

	// Idle length: mostly short, a few long.
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 80) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	// Receiver stalls at random, with calm stretches where it never stalls.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) begin
			recv_calm = !recv_calm;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			res_ready <= 1'b0;
		end else if (!recv_calm && $urandom_range(0, 99) < 30) begin
			stall_left = gap_length() - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function automatic obs_t make_obs(input bit bd, input int prn, input int elev,
			input logic [RANGE_W-1:0] b1, input logic [RANGE_W-1:0] b2,
			input logic [RANGE_W-1:0] b3, input bit last);
		obs_t o;
		o.is_beidou = bd;
		o.prn = PRN_W'(prn);
		o.elevation = ELEV_W'(elev);
		o.range_b1 = b1;
		o.range_b2 = b2;
		o.range_b3 = b3;
		o.last_in_epoch = last;
		return o;
	endfunction

	// Pseudorange mix: full-scale, near zero and near the top of the range.
	function automatic logic [RANGE_W-1:0] rand_range();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return {4'($urandom_range(0, 15)), 32'($urandom())};
		end else if (pick < 80) begin
			return RANGE_W'($urandom_range(0, 1200));
		end
		return RANGE_TOP - RANGE_W'($urandom_range(0, 1200));
	endfunction

	// Positive elevation, weighted toward table boundaries and the top.
	function automatic int rand_pos_elev();
		int pick;
		int e;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			e = $urandom_range(0, 9) * DEG10 + $urandom_range(0, 2) - 1;
		end else if (pick < 20) begin
			e = ELEV_TOP;
		end else if (pick < 25) begin
			e = $urandom_range(0, 8) * DEG10 + DEG10 / 2;
		end else begin
			e = $urandom_range(1, ELEV_TOP - 1);
		end
		if (e < 1) begin
			e = 1;
		end
		return e;
	endfunction

	// Presents one observation and holds it until the unit takes it.
	task automatic send_obs(input obs_t o);
		int gap;
		if ($urandom_range(0, 59) == 0) begin
			send_calm = !send_calm;
		end
		gap = (send_calm || $urandom_range(0, 99) < 50) ? 0 : gap_length();
		if (gap > 0) begin
			obs_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		obs <= o;
		obs_valid <= 1'b1;
		do @(posedge clk); while (!obs_ready);
	endtask

	initial begin : stimulus
		obs_t o;
		int pick;
		int prn;
		bit bd;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: satellite classes, elevation edges, rounding and saturation.
		send_obs(make_obs(1, 11, ELEV_TOP, RANGE_TOP, RANGE_TOP, RANGE_TOP, 0));
		send_obs(make_obs(1, 6, 1, '0, '0, '0, 0));
		send_obs(make_obs(0, 11, 11520, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 0, 11520, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 5, 11520, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 1));
		send_obs(make_obs(1, 10, 11520, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 63, 11520, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 12, 0, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 12, -1, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 12, -ELEV_TOP, RANGE_TOP, '0, TYPICAL_RANGE, 1));
		send_obs(make_obs(1, 7, DEG10 - 1, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 7, DEG10, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 7, DEG10 + 1, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 20, DEG10 / 2, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 20, ELEV_TOP - 1, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 20, 32767, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 8, -32768, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 1));
		// IGSO B1 bias rounds to zero here, yet the correction still counts.
		send_obs(make_obs(1, 6, 13588, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 30, 20480, TYPICAL_RANGE, TYPICAL_RANGE, TYPICAL_RANGE, 0));
		send_obs(make_obs(1, 9, ELEV_TOP, 36'h5_5555_5555, 36'hA_AAAA_AAAA, 36'd550, 0));
		send_obs(make_obs(1, 11, 1, 36'd469, 36'd470, 36'd471, 1));
		send_obs(make_obs(1, 40, 8192, RANGE_TOP - 36'd100, 36'd50, 36'd100, 0));
		send_obs(make_obs(0, 0, 0, '0, '0, '0, 0));

		// Random: mostly correctable satellites, the rest pass-through cases.
		for (int n = 0; n < RANDOM_OBS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				bd = 1'b1;
				prn = ($urandom_range(0, 1) == 1) ? $urandom_range(FIRST_IGSO, FIRST_MEO - 1)
					: $urandom_range(FIRST_MEO, 63);
				o = make_obs(bd, prn, rand_pos_elev(), rand_range(), rand_range(),
					rand_range(), $urandom_range(0, 1));
			end else if (pick < 85) begin
				bd = $urandom_range(0, 1);
				prn = bd ? $urandom_range(0, FIRST_IGSO - 1) : $urandom_range(0, 63);
				o = make_obs(bd, prn, $urandom_range(0, 2 * ELEV_TOP) - ELEV_TOP, rand_range(),
					rand_range(), rand_range(), $urandom_range(0, 1));
			end else begin
				o = make_obs($urandom_range(0, 1), $urandom_range(0, 63),
					-$urandom_range(0, ELEV_TOP), rand_range(), rand_range(), rand_range(),
					$urandom_range(0, 1));
			end
			send_obs(o);
		end
		obs_valid <= 1'b0;

		// Drain the pipeline, then keep the clock running before the summary.
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d IGSO and %0d MEO corrections, %0d unchanged.",
			checked_count, igso_count, meo_count, checked_count - igso_count - meo_count);
		$display("Lanes held at a range limit: %0d; mismatches: %0d.", clamp_count, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("** beidou_code_bias_correction_unit: PASSED **");
		end else begin
			$display("** beidou_code_bias_correction_unit: FAILED **");
		end
		$finish;
	end

endmodule
